@@ sv/fspa_pkg.sv @@
// Shared types and constants for the slot pool allocator.
// No dependencies; fspa_ctrl, fspa_dp and the top level import this package.
package fspa_pkg;

    localparam int SLOT_W = 8;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    // Request codes.
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_TRY   = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK            = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY         = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_ALLOCATED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED     = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              pop_issue;   // read the queue head, advance head and count
        logic              pop_finish;  // take the read data as the granted slot
        logic              create;      // hand out a never-used slot
        logic              dealloc;     // clear the slot's bit and queue it
        logic              load_direct; // load the result register this cycle
        logic [STAT_W-1:0] status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic queue_empty;
        logic pool_full;
        logic slot_in_use;
        logic out_free;
    } stat_t;

endpackage

@@ sv/fspa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fspa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/fspa_ctrl.sv @@
// Request sequencer of the slot pool allocator.
// Depends on fspa_pkg; drives the datapath through cmd_t and reads stat_t.
module fspa_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic [fspa_pkg::OP_W-1:0]   operation,
    input  fspa_pkg::stat_t             stat,
    output logic                        s_tready,
    output fspa_pkg::cmd_t              cmd
);
    import fspa_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    // A request is taken only when the result register is empty or draining.
    assign s_tready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = STAT_OK;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (operation)
                        OP_ALLOC: begin
                            if (!stat.queue_empty) begin
                                cmd.pop_issue = 1'b1;
                                state_next    = S_POP;
                            end else if (!stat.pool_full) begin
                                cmd.create      = 1'b1;
                                cmd.load_direct = 1'b1;
                            end else begin
                                cmd.load_direct = 1'b1;
                                cmd.status      = STAT_EXHAUSTED;
                            end
                        end
                        OP_TRY: begin
                            if (!stat.queue_empty) begin
                                cmd.pop_issue = 1'b1;
                                state_next    = S_POP;
                            end else begin
                                cmd.load_direct = 1'b1;
                                cmd.status      = STAT_EMPTY;
                            end
                        end
                        OP_FREE: begin
                            cmd.dealloc     = 1'b1;
                            cmd.load_direct = 1'b1;
                            if (!stat.slot_in_use) begin
                                cmd.status = STAT_NOT_ALLOCATED;
                            end
                        end
                        default: begin
                            cmd.load_direct = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                cmd.pop_finish = 1'b1;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/fspa_dp.sv @@
// Datapath of the slot pool allocator: free queue, in-use bitmap, creation
// counter and result register. Depends on fspa_pkg and fspa_ram.
module fspa_dp #(
    parameter int POOL_SLOTS = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fspa_pkg::cmd_t                cmd,
    input  logic [fspa_pkg::SLOT_W-1:0]   slot,
    input  logic                          m_tready,
    output fspa_pkg::stat_t               stat,
    output logic                          m_tvalid,
    output logic [fspa_pkg::SLOT_W-1:0]   granted_slot,
    output logic [fspa_pkg::STAT_W-1:0]   status
);
    import fspa_pkg::*;

    localparam int PTR_W     = $clog2(POOL_SLOTS);
    localparam int CNT_W     = $clog2(POOL_SLOTS + 1);
    // Only slots 0..255 can ever be named by a release, so only those bits matter.
    localparam int MAP_DEPTH = (POOL_SLOTS < (1 << SLOT_W)) ? POOL_SLOTS : (1 << SLOT_W);
    localparam int MAP_W     = $clog2(MAP_DEPTH);

    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     created_reg, created_next;
    logic [MAP_DEPTH-1:0] in_use_reg, in_use_next;
    logic                 valid_reg, valid_next;
    logic [SLOT_W-1:0]    granted_reg, granted_next;
    logic [STAT_W-1:0]    status_reg, status_next;

    logic              slot_in_range;
    logic              slot_ok;
    logic              push;
    logic [SLOT_W-1:0] rd_data;
    logic [31:0]       created_ext;

    assign slot_in_range = 32'(slot) < 32'(POOL_SLOTS);
    assign slot_ok       = slot_in_range && in_use_reg[slot[MAP_W-1:0]];
    // The queue can never overflow, but a push into a full queue is dropped.
    assign push          = cmd.dealloc && slot_ok && (count_reg < CNT_W'(POOL_SLOTS));
    assign created_ext   = 32'(created_reg);

    fspa_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(POOL_SLOTS)
    ) u_free_queue (
        .aclk  (aclk),
        .we    (push),
        .waddr (tail_reg),
        .wdata (slot),
        .re    (cmd.pop_issue),
        .raddr (head_reg),
        .rdata (rd_data)
    );

    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        created_next = created_reg;
        in_use_next  = in_use_reg;
        valid_next   = valid_reg && !m_tready;
        granted_next = granted_reg;
        status_next  = status_reg;

        if (cmd.pop_issue) begin
            head_next  = (head_reg == PTR_W'(POOL_SLOTS - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (push) begin
            tail_next  = (tail_reg == PTR_W'(POOL_SLOTS - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        if (cmd.dealloc && slot_ok) begin
            in_use_next[slot[MAP_W-1:0]] = 1'b0;
        end
        if (cmd.create) begin
            created_next = created_reg + 1'b1;
            if (created_reg < CNT_W'(MAP_DEPTH)) begin
                in_use_next[created_reg[MAP_W-1:0]] = 1'b1;
            end
        end
        if (cmd.pop_finish) begin
            in_use_next[rd_data[MAP_W-1:0]] = 1'b1;
            valid_next   = 1'b1;
            granted_next = rd_data;
            status_next  = STAT_OK;
        end
        if (cmd.load_direct) begin
            valid_next   = 1'b1;
            granted_next = cmd.create ? created_ext[SLOT_W-1:0] : '0;
            status_next  = cmd.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            created_reg <= '0;
            in_use_reg  <= '0;
            valid_reg   <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            created_reg <= created_next;
            in_use_reg  <= in_use_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    assign stat.queue_empty = (count_reg == '0);
    assign stat.pool_full   = (created_reg == CNT_W'(POOL_SLOTS));
    assign stat.slot_in_use = slot_ok;
    assign stat.out_free    = !valid_reg || m_tready;

    assign m_tvalid     = valid_reg;
    assign granted_slot = granted_reg;
    assign status       = status_reg;

endmodule

@@ sv/fifo_slot_pool_allocator_unit.sv @@
// Top level of the slot pool allocator: FIFO free list plus in-use bitmap.
// Depends on fspa_pkg, fspa_ctrl, fspa_dp and fspa_ram.
//
// Usage:
//   The request channel (s_) carries the operation in s_tuser and, for a
//   release, the slot index in s_tdata. Every request yields exactly one
//   result transfer on the m_ channel: the granted slot in m_tdata (zero
//   unless an allocation succeeded) and the status code in m_tuser.
//   Allocate takes the oldest released slot, else a fresh slot, else reports
//   pool exhausted. Try allocate only uses released slots. Release checks
//   the in-use bitmap and queues the slot.
//   A result that needs no queue read is valid in the cycle after the request
//   transfer; a slot from the free queue passes through the registered RAM
//   read port, then the result register. While m_tready is high, requests that
//   need no queue read are taken every cycle; a queue read holds s_tready low.
//   The single result register holds the result while m_tready is low;
//   s_tready stays low until that result is taken or being taken.
//   Reset clears the bitmap, queue pointers, creation counter and any
//   pending result; the block is ready in the first cycle after reset.
module fifo_slot_pool_allocator_unit #(
    parameter int POOL_SLOTS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] slot
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] granted_slot
    output logic [1:0]  m_tuser    // [1:0] status
);
    import fspa_pkg::*;

    cmd_t  ctrl_cmd;
    stat_t dp_stat;

    fspa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .operation (s_tuser),
        .stat      (dp_stat),
        .s_tready  (s_tready),
        .cmd       (ctrl_cmd)
    );

    fspa_dp #(
        .POOL_SLOTS(POOL_SLOTS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (ctrl_cmd),
        .slot         (s_tdata),
        .m_tready     (m_tready),
        .stat         (dp_stat),
        .m_tvalid     (m_tvalid),
        .granted_slot (m_tdata),
        .status       (m_tuser)
    );

    // A request is only taken when its result has room to land.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("request taken while a result is stalled");

    // Every request either shows its result next cycle or finishes a queue read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (m_tvalid || ctrl_cmd.pop_finish))
        else $error("request produced no result");

    // The queue is never popped while empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.pop_issue |-> !dp_stat.queue_empty)
        else $error("pop from empty free queue");

    // Failed requests hand out no slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != STAT_OK)) |-> (m_tdata == '0))
        else $error("slot granted with an error status");

endmodule

@@ tb/sv/tb_fifo_slot_pool_allocator_unit.sv @@
// Self-checking testbench for the slot pool allocator top level.
// Depends on fspa_pkg and fifo_slot_pool_allocator_unit; drives requests on the s_ stream,
// tracks free-queue and bitmap state itself and checks every result transfer on m_.
module tb_fifo_slot_pool_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fspa_pkg::*;

    localparam int NUM_SLOTS = 256;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        bit                calm;
    } pool_req_t;

    typedef struct {
        logic [SLOT_W-1:0] granted;
        logic [STAT_W-1:0] status;
    } pool_result_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;
    logic [1:0]        s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;
    logic [1:0]        m_tuser;

    pool_req_t         pending_reqs[$];
    pool_result_t      expected_grants[$];

    // Shadow of the allocator state.
    logic [SLOT_W-1:0] shadow_free_fifo[$];
    bit                shadow_in_use[NUM_SLOTS];
    int unsigned       shadow_created;

    int unsigned       total_reqs;
    int unsigned       reqs_accepted;
    int unsigned       results_seen;
    int unsigned       mismatches;
    int unsigned       allocs_issued;
    int unsigned       tx_gap;
    int unsigned       rx_hold;
    bit                calm_phase = 1'b0;
    bit                long_stall = 1'b0;
    pool_req_t         next_req;
    pool_result_t      want;

    fifo_slot_pool_allocator_unit #(
        .POOL_SLOTS(NUM_SLOTS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 30) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
    endtask

    // Applies one accepted request to the shadow state and queues its result.
    function automatic void model_pool_request(input logic [OP_W-1:0] op,
                                               input logic [SLOT_W-1:0] slot);
        pool_result_t res;
        res.granted = '0;
        res.status  = STAT_OK;
        case (op)
            OP_ALLOC, OP_TRY: begin
                if (shadow_free_fifo.size() > 0) begin
                    res.granted = shadow_free_fifo.pop_front();
                    shadow_in_use[res.granted] = 1'b1;
                end else if (op == OP_TRY) begin
                    res.status = STAT_EMPTY;
                end else if (shadow_created < NUM_SLOTS) begin
                    res.granted = shadow_created[SLOT_W-1:0];
                    shadow_in_use[shadow_created] = 1'b1;
                    shadow_created++;
                end else begin
                    res.status = STAT_EXHAUSTED;
                end
            end
            OP_FREE: begin
                if (!shadow_in_use[slot]) begin
                    res.status = STAT_NOT_ALLOCATED;
                end else begin
                    shadow_in_use[slot] = 1'b0;
                    shadow_free_fifo.push_back(slot);
                end
            end
            default: ;
        endcase
        expected_grants.push_back(res);
    endfunction

    function automatic void add_req(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                                    input bit calm);
        pool_req_t r;
        r.op   = op;
        r.slot = slot;
        r.calm = calm;
        if (op == OP_ALLOC) begin
            allocs_issued++;
        end
        pending_reqs.push_back(r);
    endfunction

    // Random requests; releases mostly name slots that may have been handed out.
    function automatic void add_random_reqs(input int n, input int pct_alloc, input int pct_try,
                                            input int pct_free, input bit calm);
        int unsigned pick;
        int unsigned top;
        logic [SLOT_W-1:0] slot;
        logic [OP_W-1:0] op;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < pct_alloc) begin
                op = OP_ALLOC;
            end else if (pick < pct_alloc + pct_try) begin
                op = OP_TRY;
            end else if (pick < pct_alloc + pct_try + pct_free) begin
                op = OP_FREE;
            end else begin
                op = OP_UNUSED;
            end
            top = (allocs_issued > NUM_SLOTS - 1) ? NUM_SLOTS - 1 : allocs_issued;
            if (op == OP_FREE && $urandom_range(0, 99) < 85) begin
                slot = SLOT_W'($urandom_range(0, top));
            end else begin
                slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
            end
            add_req(op, slot, calm);
        end
    endfunction

    // Request driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                model_pool_request(s_tuser, s_tdata);
                reqs_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    next_req = pending_reqs.pop_front();
                    s_tvalid   <= 1'b1;
                    s_tdata    <= next_req.slot;
                    s_tuser    <= next_req.op;
                    calm_phase <= next_req.calm;
                    if (!next_req.calm && !long_stall && $urandom_range(0, 7) == 0) begin
                        tx_gap = $urandom_range(1, 10);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_grants.size() == 0) begin
                    flag_mismatch($sformatf("result with none expected: slot %0d status %0d",
                                            m_tdata, m_tuser));
                end else begin
                    want = expected_grants.pop_front();
                    if (m_tdata !== want.granted) begin
                        flag_mismatch($sformatf("result %0d granted_slot %0d, expected %0d",
                                                results_seen, m_tdata, want.granted));
                    end
                    if (m_tuser !== want.status) begin
                        flag_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                results_seen, m_tuser, want.status));
                    end
                end
            end
            if (long_stall) begin
                m_tready <= 1'b0;
            end else if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
                rx_hold = $urandom_range(1, 10) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // One long receiver hold-off so the result register fills and s_tready drops.
    initial begin
        while (results_seen < 60) @(posedge aclk);
        long_stall <= 1'b1;
        repeat (80) @(posedge aclk);
        long_stall <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        reqs_accepted  = 0;
        results_seen   = 0;
        mismatches     = 0;
        allocs_issued  = 0;
        shadow_created = 0;

        // Directed part: empty pool, bad releases, FIFO order of reuse, unused code.
        add_req(OP_TRY, 8'h00, 1'b0);
        add_req(OP_FREE, 8'h00, 1'b0);
        add_req(OP_FREE, 8'hFF, 1'b0);
        add_req(OP_UNUSED, 8'hAA, 1'b0);
        add_req(OP_ALLOC, 8'h55, 1'b0);
        add_req(OP_ALLOC, 8'hFF, 1'b0);
        add_req(OP_ALLOC, 8'h00, 1'b0);
        add_req(OP_FREE, 8'h01, 1'b0);
        add_req(OP_FREE, 8'h01, 1'b0);
        add_req(OP_FREE, 8'h00, 1'b0);
        add_req(OP_TRY, 8'hFF, 1'b0);
        add_req(OP_ALLOC, 8'h00, 1'b0);
        add_req(OP_TRY, 8'hAA, 1'b0);
        add_req(OP_FREE, 8'h02, 1'b0);
        add_req(OP_FREE, 8'h00, 1'b0);
        add_req(OP_ALLOC, 8'h00, 1'b0);
        add_req(OP_ALLOC, 8'h00, 1'b0);
        add_req(OP_ALLOC, 8'h00, 1'b0);
        add_req(OP_UNUSED, 8'h55, 1'b0);
        add_req(OP_FREE, 8'h03, 1'b0);
        add_req(OP_FREE, 8'hFE, 1'b0);

        // Mixed traffic, then an allocation burst that runs the pool dry,
        // then recycling after exhaustion without any idling.
        add_random_reqs(200, 55, 12, 28, 1'b0);
        add_random_reqs(300, 88, 3, 6, 1'b0);
        add_random_reqs(150, 30, 20, 48, 1'b1);
        total_reqs = pending_reqs.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (reqs_accepted < total_reqs) @(posedge aclk);
        while (expected_grants.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
